[rtl/core/cpsp_pkg.sv]
// cpsp_pkg: shared widths, register map, sequencer states and control structs
// for the cascaded position/speed controller. No dependencies.
package cpsp_pkg;

	localparam int unsigned POS_W      = 32;
	localparam int unsigned SPD_W      = 16;
	localparam int unsigned GAIN_W     = 16;
	localparam int unsigned LIM_W      = 15;
	localparam int unsigned INTEG_W    = 28;
	localparam int unsigned SERR_W     = SPD_W + 1;
	localparam int unsigned MAG_W      = POS_W + 1;
	localparam int unsigned PROD_W     = MAG_W + GAIN_W;
	localparam int unsigned RES_W      = PROD_W + 2;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned S_TDATA_W  = 56;
	localparam int unsigned M_TDATA_W  = 40;

	localparam int unsigned SPEED_INTEGRAL_LIMIT_DEF = 6000;
	localparam int unsigned GAIN_FRAC_BITS_DEF       = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POSITION_TARGET = 4'd0,
		REG_POS_KP          = 4'd1,
		REG_POS_KD          = 4'd2,
		REG_POS_DEADBAND    = 4'd3,
		REG_POS_OUT_LIMIT   = 4'd4,
		REG_SPD_KP          = 4'd5,
		REG_SPD_KI          = 4'd6,
		REG_SPD_OUT_LIMIT   = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [POS_W-1:0] position_target;
		logic [GAIN_W-1:0]       pos_kp;
		logic [GAIN_W-1:0]       pos_kd;
		logic [GAIN_W-1:0]       pos_deadband;
		logic [LIM_W-1:0]        pos_out_limit;
		logic [GAIN_W-1:0]       spd_kp;
		logic [GAIN_W-1:0]       spd_ki;
		logic [LIM_W-1:0]        spd_out_limit;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_MP,
		ST_MD,
		ST_SP,
		ST_SERR,
		ST_MI,
		ST_MK,
		ST_CUR,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MUL_ERR_KP,
		MUL_DERR_KD,
		MUL_SERR_KI,
		MUL_SERR_KP
	} mul_sel_t;

	typedef struct packed {
		logic     in_ready;
		logic     ld_err;
		logic     ld_derr;
		logic     ld_acc;
		logic     ld_sp;
		logic     ld_serr;
		logic     ld_integ;
		logic     ld_cur;
		logic     ld_out;
		mul_sel_t mul_sel;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic en;
		logic dead;
		logic out_free;
	} stat_t;

	// symmetric clamp to +-lim
	function automatic logic signed [RES_W-1:0] sat_sym(
		input logic signed [RES_W-1:0] v,
		input logic [15:0]             lim
	);
		logic signed [RES_W-1:0] hi;
		logic signed [RES_W-1:0] lo;
		hi = $signed({{(RES_W-16){1'b0}}, lim});
		lo = -hi;
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

endpackage

[rtl/core/cpsp_cfg.sv]
// cpsp_cfg: configuration register file of the controller.
// Depends on cpsp_pkg for the register map and cfg_t.
module cpsp_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cpsp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cpsp_pkg::CFG_DATA_W-1:0]  cfg_data,
	output cpsp_pkg::cfg_t                   regs
);
	import cpsp_pkg::*;

	cfg_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.position_target <= '0;
			regs_q.pos_kp          <= 16'd819;
			regs_q.pos_kd          <= 16'd614;
			regs_q.pos_deadband    <= 16'd150;
			regs_q.pos_out_limit   <= 15'd9000;
			regs_q.spd_kp          <= 16'd36864;
			regs_q.spd_ki          <= 16'd1229;
			regs_q.spd_out_limit   <= 15'd8000;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_POSITION_TARGET: regs_q.position_target <= $signed(cfg_data[POS_W-1:0]);
				REG_POS_KP:          regs_q.pos_kp          <= cfg_data[GAIN_W-1:0];
				REG_POS_KD:          regs_q.pos_kd          <= cfg_data[GAIN_W-1:0];
				REG_POS_DEADBAND:    regs_q.pos_deadband    <= cfg_data[GAIN_W-1:0];
				REG_POS_OUT_LIMIT:   regs_q.pos_out_limit   <= cfg_data[LIM_W-1:0];
				REG_SPD_KP:          regs_q.spd_kp          <= cfg_data[GAIN_W-1:0];
				REG_SPD_KI:          regs_q.spd_ki          <= cfg_data[GAIN_W-1:0];
				REG_SPD_OUT_LIMIT:   regs_q.spd_out_limit   <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

[rtl/core/cpsp_mul.sv]
// cpsp_mul: shared sign-magnitude gain multiplier, product truncated toward zero.
// Registered product; depends on cpsp_pkg for widths.
module cpsp_mul #(
	parameter int unsigned GAIN_FRAC_BITS = cpsp_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic signed [cpsp_pkg::MAG_W-1:0]   v,
	input  logic [cpsp_pkg::GAIN_W-1:0]         gain,
	output logic signed [cpsp_pkg::RES_W-1:0]   res
);
	import cpsp_pkg::*;

	logic [MAG_W-1:0]  mag;
	logic [PROD_W-1:0] prod_q;
	logic              neg_q;
	logic [PROD_W-1:0] shr;

	assign mag = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mag) * PROD_W'(gain);
		neg_q  <= v[MAG_W-1];
	end

	// truncate the magnitude, then restore the sign
	assign shr = prod_q >> GAIN_FRAC_BITS;
	assign res = neg_q ? -$signed({2'b00, shr}) : $signed({2'b00, shr});

endmodule

[rtl/core/cpsp_seq.sv]
// cpsp_seq: sequencer that steps one control tick through the shared multiplier.
// Depends on cpsp_pkg for state_t, ctrl_t and stat_t.
module cpsp_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  cpsp_pkg::stat_t stat,
	output cpsp_pkg::ctrl_t ctrl
);
	import cpsp_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (stat.in_valid) state_nxt = ST_ERR;
			end
			ST_ERR: begin
				if (!stat.en) begin
					state_nxt = ST_DONE;
				end else if (stat.dead) begin
					state_nxt = ST_SERR;
				end else begin
					state_nxt = ST_MP;
				end
			end
			ST_MP:   state_nxt = ST_MD;
			ST_MD:   state_nxt = ST_SP;
			ST_SP:   state_nxt = ST_SERR;
			ST_SERR: state_nxt = ST_MI;
			ST_MI:   state_nxt = ST_MK;
			ST_MK:   state_nxt = ST_CUR;
			ST_CUR:  state_nxt = ST_DONE;
			ST_DONE: begin
				if (stat.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.mul_sel = MUL_ERR_KP;
		case (state_q)
			ST_IDLE: ctrl.in_ready = 1'b1;
			ST_ERR:  ctrl.ld_err   = 1'b1;
			ST_MP: begin
				ctrl.mul_sel = MUL_ERR_KP;
				ctrl.ld_derr = 1'b1;
			end
			ST_MD: begin
				ctrl.mul_sel = MUL_DERR_KD;
				ctrl.ld_acc  = 1'b1;
			end
			ST_SP:   ctrl.ld_sp   = 1'b1;
			ST_SERR: ctrl.ld_serr = 1'b1;
			ST_MI:   ctrl.mul_sel = MUL_SERR_KI;
			ST_MK: begin
				ctrl.mul_sel  = MUL_SERR_KP;
				ctrl.ld_integ = 1'b1;
			end
			ST_CUR:  ctrl.ld_cur = 1'b1;
			ST_DONE: ctrl.ld_out = stat.out_free;
			default: ;
		endcase
	end

endmodule

[rtl/core/cascaded_position_speed_pid_top.sv]
// Cascaded position/speed controller: PD position loop feeding a PI speed loop.
// Depends on cpsp_pkg, cpsp_cfg, cpsp_mul and cpsp_seq.
// One input transaction is taken only while the block is idle. A tick with both loops
// running steps through ERR, MP, MD, SP, SERR, MI, MK and CUR to DONE; inside the
// deadband it goes from ERR straight to SERR, and with control disabled from ERR to
// DONE. DONE loads the result once the output register is free, then returns to idle.
// The sequencer uses the single 33x16 gain multiplier four times per tick with both
// loops running, with a registered product. The result sits in an output register,
// so the next tick is accepted while the previous result still waits to be taken.
module cascaded_position_speed_pid_top #(
	parameter int unsigned SPEED_INTEGRAL_LIMIT = cpsp_pkg::SPEED_INTEGRAL_LIMIT_DEF,
	parameter int unsigned GAIN_FRAC_BITS       = cpsp_pkg::GAIN_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// position_count [31:0], motor_speed [47:32], control_enable [48], zero [55:49]
	input  logic [cpsp_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// current_command [15:0], speed_setpoint [31:16], in_deadband [32], zero [39:33]
	output logic [cpsp_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cpsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cpsp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import cpsp_pkg::*;

	localparam logic [15:0] INTEG_LIM = 16'(SPEED_INTEGRAL_LIMIT);
	localparam logic signed [MAG_W-1:0] ERR_MAX = $signed({2'b00, {(POS_W-1){1'b1}}});
	localparam logic signed [MAG_W-1:0] ERR_MIN = -ERR_MAX;

	cfg_t  regs;
	ctrl_t ctrl;
	stat_t stat;

	logic signed [POS_W-1:0]   pos_q;
	logic signed [SPD_W-1:0]   spd_q;
	logic                      en_q;
	logic signed [POS_W-1:0]   err_q;
	logic signed [POS_W-1:0]   last_err_q;
	logic signed [MAG_W-1:0]   derr_q;
	logic signed [RES_W-1:0]   acc_q;
	logic signed [SPD_W-1:0]   sp_q;
	logic                      dead_q;
	logic signed [SERR_W-1:0]  serr_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [SPD_W-1:0]   cur_q;
	logic [M_TDATA_W-1:0]      out_data_q;
	logic                      out_valid_q;

	logic signed [MAG_W-1:0]   diff;
	logic signed [MAG_W-1:0]   diff_sat;
	logic signed [POS_W-1:0]   err_sat;
	logic [POS_W-1:0]          err_mag;
	logic                      dead;
	logic signed [MAG_W-1:0]   mul_v;
	logic [GAIN_W-1:0]         mul_g;
	logic signed [RES_W-1:0]   mul_res;
	logic signed [RES_W-1:0]   integ_ext;
	logic signed [RES_W-1:0]   sp_sum;
	logic signed [RES_W-1:0]   integ_sum;
	logic signed [RES_W-1:0]   cur_sum;
	logic signed [RES_W-1:0]   sp_sat;
	logic signed [RES_W-1:0]   integ_sat;
	logic signed [RES_W-1:0]   cur_sat;

	cpsp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	cpsp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	cpsp_mul #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_mul (
		.clk  (clk),
		.v    (mul_v),
		.gain (mul_g),
		.res  (mul_res)
	);

	assign s_axis_tready = ctrl.in_ready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign stat.in_valid = s_axis_tvalid;
	assign stat.en       = en_q;
	assign stat.dead     = dead;
	assign stat.out_free = !out_valid_q || m_axis_tready;

	// outer error, saturated symmetrically to the 32 bit range
	assign diff = {regs.position_target[POS_W-1], regs.position_target}
		- {pos_q[POS_W-1], pos_q};

	always_comb begin
		if (diff > ERR_MAX) begin
			diff_sat = ERR_MAX;
		end else if (diff < ERR_MIN) begin
			diff_sat = ERR_MIN;
		end else begin
			diff_sat = diff;
		end
	end

	assign err_sat = diff_sat[POS_W-1:0];
	assign err_mag = err_sat[POS_W-1] ? POS_W'(-err_sat) : POS_W'(err_sat);
	assign dead    = (regs.pos_deadband != '0)
		&& (err_mag < {{(POS_W-GAIN_W){1'b0}}, regs.pos_deadband});

	always_comb begin
		case (ctrl.mul_sel)
			MUL_ERR_KP: begin
				mul_v = {err_q[POS_W-1], err_q};
				mul_g = regs.pos_kp;
			end
			MUL_DERR_KD: begin
				mul_v = derr_q;
				mul_g = regs.pos_kd;
			end
			MUL_SERR_KI: begin
				mul_v = {{(MAG_W-SERR_W){serr_q[SERR_W-1]}}, serr_q};
				mul_g = regs.spd_ki;
			end
			MUL_SERR_KP: begin
				mul_v = {{(MAG_W-SERR_W){serr_q[SERR_W-1]}}, serr_q};
				mul_g = regs.spd_kp;
			end
			default: begin
				mul_v = '0;
				mul_g = '0;
			end
		endcase
	end

	assign integ_ext = {{(RES_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
	assign sp_sum    = acc_q + mul_res;
	assign integ_sum = integ_ext + mul_res;
	assign cur_sum   = mul_res + integ_ext;
	assign sp_sat    = sat_sym(sp_sum, {1'b0, regs.pos_out_limit});
	assign integ_sat = sat_sym(integ_sum, INTEG_LIM);
	assign cur_sat   = sat_sym(cur_sum, {1'b0, regs.spd_out_limit});

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && ctrl.in_ready) begin
			pos_q <= $signed(s_axis_tdata[POS_W-1:0]);
			spd_q <= $signed(s_axis_tdata[POS_W+SPD_W-1:POS_W]);
			en_q  <= s_axis_tdata[POS_W+SPD_W];
		end
		if (ctrl.ld_err) begin
			err_q  <= err_sat;
			dead_q <= dead;
			if (dead) sp_q <= '0;
		end
		if (ctrl.ld_derr) derr_q <= {err_q[POS_W-1], err_q} - {last_err_q[POS_W-1], last_err_q};
		if (ctrl.ld_acc)  acc_q  <= mul_res;
		if (ctrl.ld_sp)   sp_q   <= sp_sat[SPD_W-1:0];
		if (ctrl.ld_serr) serr_q <= {sp_q[SPD_W-1], sp_q} - {spd_q[SPD_W-1], spd_q};
		if (ctrl.ld_cur)  cur_q  <= cur_sat[SPD_W-1:0];
		if (ctrl.ld_out) begin
			if (en_q) begin
				out_data_q <= {{(M_TDATA_W-2*SPD_W-1){1'b0}}, dead_q, sp_q, cur_q};
			end else begin
				out_data_q <= '0;
			end
		end
	end

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			integ_q    <= '0;
		end else begin
			if (ctrl.ld_sp)    last_err_q <= err_q;
			if (ctrl.ld_integ) integ_q    <= integ_sat[INTEG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/core/cpsp_chk.sv]
// cpsp_chk: port-level checks for the cascaded controller, bound to the top level.
// No package dependency; sees the top-level ports only.
module cpsp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready
);

	// one tick at a time: busy right after an input transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while a tick is still in work");

	// a deadband result never carries a setpoint
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[32]) |-> (m_axis_tdata[31:16] == 16'd0))
		else $error("deadband result with nonzero setpoint");

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result changed or dropped while stalled");

endmodule

bind cascaded_position_speed_pid_top cpsp_chk u_cpsp_chk (.*);
